@@ src/tsfs_pkg.sv @@
// ----------------------------------------------------------------------------
// Tempo-synced frame stutter control: shared definitions
// Field widths, tempo and note constants, and the note length decode.
// ----------------------------------------------------------------------------
package tsfs_pkg;

  localparam int RATE_W = 10;
  localparam int BPM_W  = 18;
  localparam int TIME_W = 40;
  localparam int SLOT_W = 7;

  localparam int RING_SLOTS_DEFAULT = 128;

  localparam logic [BPM_W-1:0] DEFAULT_BPM_RESET = BPM_W'(30720);
  localparam logic [BPM_W-1:0] BPM_FLOOR         = BPM_W'(256);

  // 1/8 beat at 1 bpm in 1/256 bpm units times microseconds
  localparam int                  THRESH_W          = 36;
  localparam logic [THRESH_W-1:0] EIGHTH_BEAT_UNITS = THRESH_W'(64'd1920000000);

  localparam logic [RATE_W-1:0] RATE_FOUR_BEATS = RATE_W'(100);
  localparam logic [RATE_W-1:0] RATE_TWO_BEATS  = RATE_W'(300);
  localparam logic [RATE_W-1:0] RATE_ONE_BEAT   = RATE_W'(500);
  localparam logic [RATE_W-1:0] RATE_HALF_BEAT  = RATE_W'(700);
  localparam logic [RATE_W-1:0] RATE_QTR_BEAT   = RATE_W'(900);

  // shift of the 1/8 beat threshold: 5 for 4 beats down to 0 for 1/8
  function automatic logic [2:0] note_shift(input logic [RATE_W-1:0] rate);
    logic [2:0] k;
    priority if (rate < RATE_FOUR_BEATS) k = 3'd5;
    else if (rate < RATE_TWO_BEATS)      k = 3'd4;
    else if (rate < RATE_ONE_BEAT)       k = 3'd3;
    else if (rate < RATE_HALF_BEAT)      k = 3'd2;
    else if (rate < RATE_QTR_BEAT)       k = 3'd1;
    else                                 k = 3'd0;
    return k;
  endfunction

endpackage

@@ src/tsfs_if.sv @@
// ----------------------------------------------------------------------------
// Tempo-synced frame stutter control: channel interfaces
// Frame item channel and result channel, valid/ready with payload.
// ----------------------------------------------------------------------------
interface tsfs_frame_if
  import tsfs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              engage;
  logic [RATE_W-1:0] rate_milli;
  logic [BPM_W-1:0]  bpm_q8;
  logic [TIME_W-1:0] time_us;

  modport source (output valid, engage, rate_milli, bpm_q8, time_us, input ready);
  modport sink   (input valid, engage, rate_milli, bpm_q8, time_us, output ready);
endinterface

interface tsfs_result_if
  import tsfs_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              record_frame;
  logic [SLOT_W-1:0] record_slot;
  logic              show_recorded;
  logic [SLOT_W-1:0] play_slot;

  modport source (output valid, record_frame, record_slot, show_recorded, play_slot,
                  input ready);
  modport sink   (input valid, record_frame, record_slot, show_recorded, play_slot,
                  output ready);
endinterface

@@ src/tempo_synced_frame_stutter_control.sv @@
// ----------------------------------------------------------------------------
// Tempo-synced frame stutter control
// Per-frame capture and loop playback control for a frame ring.
// ----------------------------------------------------------------------------
// Pipeline: input register, then result register; a frame moves on when the
// result register is empty or its result is being taken.
// Throughput: one frame per cycle unless the result channel stalls; the state
// update and 36x18 interval product sit in the single stage between registers.
// Reset (rst, synchronous): idle, counters cleared, default tempo 120 bpm.
// ----------------------------------------------------------------------------
module tempo_synced_frame_stutter_control
  import tsfs_pkg::*;
#(
  parameter int RING_SLOTS = RING_SLOTS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [BPM_W-1:0] cfg_wr_data,
  tsfs_frame_if.sink       frame,
  tsfs_result_if.source    result
);

  localparam int CNT_W = $clog2(RING_SLOTS + 1);
  localparam int POS_W = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam logic [CNT_W-1:0] SLOTS = CNT_W'(RING_SLOTS);
  localparam int PROD_W = THRESH_W + BPM_W;

  logic [BPM_W-1:0] default_bpm;

  // input register
  logic              in_vld;
  logic              in_engage;
  logic [RATE_W-1:0] in_rate;
  logic [BPM_W-1:0]  in_bpm;
  logic [TIME_W-1:0] in_time;

  // control state
  logic              capturing;
  logic              looping;
  logic [CNT_W-1:0]  write_count;
  logic [CNT_W-1:0]  loop_length;
  logic [POS_W-1:0]  play_position;
  logic [TIME_W-1:0] capture_start;

  // result register
  logic              out_vld;
  logic              record_frame;
  logic [SLOT_W-1:0] record_slot;
  logic              show_recorded;
  logic [SLOT_W-1:0] play_slot;

  logic advance;
  assign advance     = in_vld && (!out_vld || result.ready);
  assign frame.ready = !in_vld || advance;

  // next-state logic
  logic [BPM_W-1:0]    tempo;
  logic [THRESH_W-1:0] threshold;
  logic                start;
  logic [CNT_W-1:0]    wc_cur;
  logic [TIME_W-1:0]   cs_cur;
  logic [TIME_W-1:0]   elapsed;
  logic [PROD_W-1:0]   product;
  logic                time_hit;
  logic                rec;
  logic [CNT_W-1:0]    wc_new;
  logic                full;
  logic [CNT_W-1:0]    pos_inc;
  logic [CNT_W+SLOT_W-1:0] rec_slot_ext;
  logic [POS_W+SLOT_W-1:0] play_slot_ext;

  logic              capturing_next;
  logic              looping_next;
  logic [CNT_W-1:0]  write_count_next;
  logic [CNT_W-1:0]  loop_length_next;
  logic [POS_W-1:0]  play_position_next;
  logic [TIME_W-1:0] capture_start_next;
  logic              record_frame_next;
  logic [SLOT_W-1:0] record_slot_next;
  logic              show_recorded_next;
  logic [SLOT_W-1:0] play_slot_next;

  always_comb begin
    tempo     = (in_bpm > BPM_FLOOR) ? in_bpm : default_bpm;
    threshold = EIGHTH_BEAT_UNITS << note_shift(in_rate);
    start     = !capturing && !looping;
    wc_cur    = start ? '0 : write_count;
    cs_cur    = start ? in_time : capture_start;
    elapsed   = in_time - cs_cur;
    product   = PROD_W'(elapsed[THRESH_W-1:0]) * PROD_W'(tempo);
    // at or above 2^36 us any non-zero tempo passes the largest threshold
    time_hit  = ((|elapsed[TIME_W-1:THRESH_W]) && (tempo != '0)) ||
                (product >= PROD_W'(threshold));
    rec       = (wc_cur < SLOTS);
    wc_new    = wc_cur + CNT_W'(rec);
    full      = time_hit || (wc_new >= SLOTS);
    pos_inc   = CNT_W'(play_position) + CNT_W'(1);
    rec_slot_ext  = {{SLOT_W{1'b0}}, wc_cur};
    play_slot_ext = {{SLOT_W{1'b0}}, play_position};

    capturing_next     = capturing;
    looping_next       = looping;
    write_count_next   = write_count;
    loop_length_next   = loop_length;
    play_position_next = play_position;
    capture_start_next = capture_start;
    record_frame_next  = 1'b0;
    record_slot_next   = '0;
    show_recorded_next = 1'b0;
    play_slot_next     = '0;

    if (!in_engage) begin
      capturing_next   = 1'b0;
      looping_next     = 1'b0;
      loop_length_next = '0;
    end else if (capturing || start) begin
      capture_start_next = cs_cur;
      write_count_next   = wc_new;
      capturing_next     = 1'b1;
      if (rec) begin
        record_frame_next = 1'b1;
        record_slot_next  = rec_slot_ext[SLOT_W-1:0];
      end
      if (full) begin
        loop_length_next   = (wc_new == '0) ? CNT_W'(1) : wc_new;
        play_position_next = '0;
        capturing_next     = 1'b0;
        looping_next       = 1'b1;
      end
    end else if (looping && (loop_length != '0)) begin
      show_recorded_next = 1'b1;
      play_slot_next     = play_slot_ext[SLOT_W-1:0];
      play_position_next = (pos_inc >= loop_length) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      default_bpm   <= DEFAULT_BPM_RESET;
      in_vld        <= 1'b0;
      out_vld       <= 1'b0;
      capturing     <= 1'b0;
      looping       <= 1'b0;
      write_count   <= '0;
      loop_length   <= '0;
      play_position <= '0;
      capture_start <= '0;
    end else begin
      if (cfg_wr_en) begin
        default_bpm <= cfg_wr_data;
      end
      if (frame.valid && frame.ready) begin
        in_vld <= 1'b1;
      end else if (advance) begin
        in_vld <= 1'b0;
      end
      if (advance) begin
        out_vld       <= 1'b1;
        capturing     <= capturing_next;
        looping       <= looping_next;
        write_count   <= write_count_next;
        loop_length   <= loop_length_next;
        play_position <= play_position_next;
        capture_start <= capture_start_next;
      end else if (result.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (frame.valid && frame.ready) begin
      in_engage <= frame.engage;
      in_rate   <= frame.rate_milli;
      in_bpm    <= frame.bpm_q8;
      in_time   <= frame.time_us;
    end
    if (advance) begin
      record_frame  <= record_frame_next;
      record_slot   <= record_slot_next;
      show_recorded <= show_recorded_next;
      play_slot     <= play_slot_next;
    end
  end

  assign result.valid         = out_vld;
  assign result.record_frame  = record_frame;
  assign result.record_slot   = record_slot;
  assign result.show_recorded = show_recorded;
  assign result.play_slot     = play_slot;

endmodule
